// File: hdl/cfls_pkg.sv
// shared types and constants for the cell inside-fraction pipeline
// no dependencies
package cfls_pkg;
    localparam int unsigned CORNERS = 4;
    typedef logic [1:0] t_corner_idx;
endpackage

// File: hdl/cfls_div.sv
// pipelined restoring divider, one quotient bit per stage
// uses cfls_pkg
module cfls_div #(
    parameter int unsigned NW = 24,
    parameter int unsigned QW = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [NW:0]   i_den,
    output logic [QW-1:0] o_quo
);
    import cfls_pkg::*;
    // quotient = (num << (QW-1)) / den, num <= den so quotient fits QW bits
    logic [NW:0]   r_rem [QW-1];
    logic [NW:0]   r_den [QW-1];
    logic [QW-1:0] r_q   [QW];
    logic [NW+1:0] w_t    [QW];
    logic [NW+1:0] w_d    [QW];
    logic [NW+1:0] w_diff [QW];
    logic          w_ge   [QW];

    always_comb begin
        // first stage compares the unshifted numerator
        w_t[0] = {2'b00, i_num};
        w_d[0] = {1'b0, i_den};
        for (int s = 1; s < QW; s++) begin
            w_t[s] = {r_rem[s-1], 1'b0};
            w_d[s] = {1'b0, r_den[s-1]};
        end
        for (int s = 0; s < QW; s++) begin
            w_ge[s]   = w_t[s] >= w_d[s];
            w_diff[s] = w_t[s] - w_d[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= {{(QW-1){1'b0}}, w_ge[0]};
            for (int s = 1; s < QW; s++) r_q[s] <= {r_q[s-1][QW-2:0], w_ge[s]};
            for (int s = 0; s < QW-1; s++) begin
                r_rem[s] <= w_ge[s] ? w_diff[s][NW:0] : w_t[s][NW:0];
            end
            r_den[0] <= i_den;
            for (int s = 1; s < QW-1; s++) r_den[s] <= r_den[s-1];
        end
    end
    assign o_quo = r_q[QW-1];
endmodule

// File: hdl/cell_fraction_inside_level_set.sv
// marching-squares inside-area fraction of one unit cell
// pipeline: FRAC_BITS+1 stage divider pipeline plus front and back stages
// throughput: one cell per cycle while not stalled, set by the fully pipelined per-edge dividers
// stalls freeze the whole pipeline; nothing is lost or repeated
// reset (synchronous, active low) clears only the valid bits
// uses cfls_pkg and cfls_div
module cell_fraction_inside_level_set #(
    parameter int unsigned DIST_WIDTH = 24,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // bl, br, tl, tr from lowest bits, DIST_WIDTH each, zero padded
    input  logic [((4*DIST_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // inside_fraction, zero padded
    output logic [((FRAC_BITS+8)/8)*8-1:0] m_axis_tdata
);
    import cfls_pkg::*;
    localparam int unsigned W   = DIST_WIDTH;
    localparam int unsigned QW  = FRAC_BITS + 1;
    localparam int unsigned LAT = QW + 3;
    localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

    // how an edge fraction is formed
    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_DIV  = 2'd1;
    localparam logic [1:0] KIND_ONE  = 2'd2;

    logic w_en;
    logic [LAT-1:0] r_vld;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
    end

    // stage 0: rotate cyclic corner list to canonical orientation
    logic signed [W-1:0] w_c [4];
    assign w_c[0] = s_axis_tdata[0*W +: W];
    assign w_c[1] = s_axis_tdata[1*W +: W];
    assign w_c[2] = s_axis_tdata[3*W +: W];
    assign w_c[3] = s_axis_tdata[2*W +: W];

    logic [3:0] w_neg;
    logic [2:0] w_cnt;
    t_corner_idx w_r;
    always_comb begin
        w_cnt = '0;
        for (int i = 0; i < 4; i++) begin
            w_neg[i] = w_c[i][W-1];
            w_cnt = w_cnt + 3'(w_neg[i]);
        end
        w_r = '0;
        for (int i = 3; i >= 0; i--) begin
            logic ok;
            ok = 1'b0;
            if (w_cnt == 3'd3) ok = !w_neg[i];
            else if (w_cnt == 3'd2)
                ok = w_neg[i] && (w_neg[(i+1)%4] || w_neg[(i+2)%4]);
            else ok = w_neg[i];
            if (ok) w_r = t_corner_idx'(i);
        end
    end

    logic signed [W-1:0] r_l [4];
    logic [2:0] r_cnt0;
    logic signed [W+1:0] r_sum;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) r_l[i] <= w_c[(i + int'(w_r)) % 4];
            r_cnt0 <= w_cnt;
            r_sum  <= (W+2)'(w_c[0]) + (W+2)'(w_c[1]) + (W+2)'(w_c[2]) + (W+2)'(w_c[3]);
        end
    end

    // stage 1: edge operands; edges l0-l3, l0-l1, l2-l1, l2-l3
    logic [W-1:0] w_num [4];
    logic [W:0]   w_den [4];
    logic [1:0]   w_kind [4];
    always_comb begin
        for (int e = 0; e < 4; e++) begin
            logic signed [W-1:0] a, b, n, p;
            a = r_l[(e < 2) ? 0 : 2];
            b = r_l[(e == 0 || e == 3) ? 3 : 1];
            if (a[W-1] && b[W-1]) begin
                w_kind[e] = KIND_ONE; n = '0; p = '0;
            end else if (a[W-1]) begin
                w_kind[e] = KIND_DIV; n = a; p = b;
            end else if (b[W-1]) begin
                w_kind[e] = KIND_DIV; n = b; p = a;
            end else begin
                w_kind[e] = KIND_ZERO; n = '0; p = '0;
            end
            w_num[e] = W'(-(W+1)'(n));
            w_den[e] = (W+1)'(-(W+1)'(n)) + (W+1)'(p);
            if (w_kind[e] != KIND_DIV) w_den[e] = (W+1)'(1);
        end
    end

    logic [QW-1:0] w_q [4];
    for (genvar e = 0; e < 4; e++) begin : g_div
        cfls_div #(.NW(W), .QW(QW)) u_div (
            .i_clk(i_clk), .i_en(w_en),
            .i_num(w_num[e]), .i_den(w_den[e]), .o_quo(w_q[e]));
    end

    // side info delayed along the divider
    typedef struct packed {
        logic [2:0] cnt;
        logic       l1neg;
        logic       sumneg;
        logic [7:0] kinds;
    } t_side;
    t_side w_side, r_side [QW];
    assign w_side = '{cnt: r_cnt0, l1neg: r_l[1][W-1], sumneg: r_sum[W+1],
                      kinds: {w_kind[3], w_kind[2], w_kind[1], w_kind[0]}};
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side;
            for (int s = 1; s < QW; s++) r_side[s] <= r_side[s-1];
        end
    end
    // r_side[QW-1] aligns with w_q (divider has QW stages after stage 1)
    t_side w_sd;
    assign w_sd = r_side[QW-1];

    // stage a: edge fractions, two products and the mean of f0 and f2
    logic [QW-1:0] w_f [4];
    logic [QW-1:0] w_x [2], w_y [2];
    logic [2*QW-1:0] r_p [2];
    logic [QW-1:0]  r_h;
    logic [2:0] r_cnt2;
    logic r_l1, r_sn;
    always_comb begin
        for (int e = 0; e < 4; e++) begin
            case (w_sd.kinds[2*e +: 2])
                KIND_ONE: w_f[e] = ONE;
                KIND_DIV: w_f[e] = w_q[e];
                default:  w_f[e] = '0;
            endcase
        end
        // default: one inside or diagonal positive sum
        w_x[0] = w_f[1]; w_y[0] = w_f[0];
        w_x[1] = w_f[2]; w_y[1] = w_f[3];
        if (w_sd.cnt == 3'd3) begin
            // cell minus the outside corner triangle
            w_x[0] = ONE - w_f[0]; w_y[0] = ONE - w_f[1];
        end else if (w_sd.cnt == 3'd2 && !w_sd.l1neg && w_sd.sumneg) begin
            w_x[0] = ONE - w_f[0]; w_y[0] = ONE - w_f[3];
            w_x[1] = ONE - w_f[1]; w_y[1] = ONE - w_f[2];
        end
        if (w_sd.cnt != 3'd2) w_x[1] = '0;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0] <= w_x[0] * w_y[0];
            r_p[1] <= w_x[1] * w_y[1];
            r_h    <= QW'(({1'b0, w_f[0]} + {1'b0, w_f[2]}) >> 1);
            r_cnt2 <= w_sd.cnt; r_l1 <= w_sd.l1neg; r_sn <= w_sd.sumneg;
        end
    end

    // stage b: combine
    logic [QW-1:0] w_s, w_res;
    logic [QW-1:0] r_res;
    always_comb begin
        w_s = QW'(r_p[0] >> (FRAC_BITS + 1)) + QW'(r_p[1] >> (FRAC_BITS + 1));
        case (r_cnt2)
            3'd4: w_res = ONE;
            3'd0: w_res = '0;
            3'd1: w_res = w_s;
            3'd3: w_res = ONE - w_s;
            default: w_res = r_l1 ? r_h : (r_sn ? ONE - w_s : w_s);
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_res <= w_res;
    end

    assign m_axis_tdata = {{($bits(m_axis_tdata)-QW){1'b0}}, r_res};
endmodule
